// File: hw/rtl/sbt_pkg.sv
// ----------------------------------------------------------------------------
// sbt_pkg
// Token kinds, scan modes and character classes shared by the tokenizer.
// ----------------------------------------------------------------------------
package sbt_pkg;

    localparam int KIND_BITS = 6;

    localparam logic [KIND_BITS-1:0] K_EQ        = 6'd0;
    localparam logic [KIND_BITS-1:0] K_YIELD     = 6'd1;
    localparam logic [KIND_BITS-1:0] K_ASSIGN    = 6'd2;
    localparam logic [KIND_BITS-1:0] K_DECLARE   = 6'd3;
    localparam logic [KIND_BITS-1:0] K_COLON     = 6'd4;
    localparam logic [KIND_BITS-1:0] K_PIPE      = 6'd5;
    localparam logic [KIND_BITS-1:0] K_OR        = 6'd6;
    localparam logic [KIND_BITS-1:0] K_SEPARATOR = 6'd7;
    localparam logic [KIND_BITS-1:0] K_AND       = 6'd8;
    localparam logic [KIND_BITS-1:0] K_NOT_EQ    = 6'd9;
    localparam logic [KIND_BITS-1:0] K_NOT       = 6'd10;
    localparam logic [KIND_BITS-1:0] K_LTE       = 6'd11;
    localparam logic [KIND_BITS-1:0] K_PUSH      = 6'd12;
    localparam logic [KIND_BITS-1:0] K_LT        = 6'd13;
    localparam logic [KIND_BITS-1:0] K_GTE       = 6'd14;
    localparam logic [KIND_BITS-1:0] K_GT        = 6'd15;
    localparam logic [KIND_BITS-1:0] K_PLUS_EQ   = 6'd16;
    localparam logic [KIND_BITS-1:0] K_PLUS      = 6'd17;
    localparam logic [KIND_BITS-1:0] K_MINUS_EQ  = 6'd18;
    localparam logic [KIND_BITS-1:0] K_MINUS     = 6'd19;
    localparam logic [KIND_BITS-1:0] K_MUL_EQ    = 6'd20;
    localparam logic [KIND_BITS-1:0] K_MULTIPLY  = 6'd21;
    localparam logic [KIND_BITS-1:0] K_DIV_EQ    = 6'd22;
    localparam logic [KIND_BITS-1:0] K_DIVIDE    = 6'd23;
    localparam logic [KIND_BITS-1:0] K_MODULO    = 6'd24;
    localparam logic [KIND_BITS-1:0] K_DOT       = 6'd25;
    localparam logic [KIND_BITS-1:0] K_COMMA     = 6'd26;
    localparam logic [KIND_BITS-1:0] K_SEMICOLON = 6'd27;
    localparam logic [KIND_BITS-1:0] K_LBRACE    = 6'd28;
    localparam logic [KIND_BITS-1:0] K_RBRACE    = 6'd29;
    localparam logic [KIND_BITS-1:0] K_LPAREN    = 6'd30;
    localparam logic [KIND_BITS-1:0] K_RPAREN    = 6'd31;
    localparam logic [KIND_BITS-1:0] K_LBRACKET  = 6'd32;
    localparam logic [KIND_BITS-1:0] K_RBRACKET  = 6'd33;
    localparam logic [KIND_BITS-1:0] K_IDENT     = 6'd34;
    localparam logic [KIND_BITS-1:0] K_INT       = 6'd35;
    localparam logic [KIND_BITS-1:0] K_FLOAT     = 6'd36;
    localparam logic [KIND_BITS-1:0] K_STRING    = 6'd37;
    localparam logic [KIND_BITS-1:0] K_ILLEGAL   = 6'd38;
    localparam logic [KIND_BITS-1:0] K_EOF       = 6'd39;

    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_QUOTE      = 8'h22;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
    localparam logic [7:0] CH_LF         = 8'h0A;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_AMP        = 8'h26;

    typedef enum logic [3:0] {
        M_IDLE, M_OP, M_IDENT, M_INT, M_INT_DOT, M_FRAC, M_STRING, M_ESC, M_COMMENT
    } mode_t;

    // result of a pair lookup
    typedef struct packed {
        logic                 paired;
        logic                 comment;
        logic [KIND_BITS-1:0] kind;
    } pair_t;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_UNDERSCORE;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == CH_LF;
    endfunction

    function automatic logic pairable(input logic [7:0] c);
        return c == "=" || c == ":" || c == "|" || c == "&" || c == "!" || c == "<" ||
               c == ">" || c == "+" || c == "-" || c == "*" || c == "/";
    endfunction

    function automatic logic [KIND_BITS-1:0] single_kind(input logic [7:0] c);
        case (c)
            "=":     return K_ASSIGN;
            ":":     return K_COLON;
            "|":     return K_SEPARATOR;
            "!":     return K_NOT;
            "<":     return K_LT;
            ">":     return K_GT;
            "+":     return K_PLUS;
            "-":     return K_MINUS;
            "*":     return K_MULTIPLY;
            "/":     return K_DIVIDE;
            "%":     return K_MODULO;
            ".":     return K_DOT;
            ",":     return K_COMMA;
            ";":     return K_SEMICOLON;
            "{":     return K_LBRACE;
            "}":     return K_RBRACE;
            "(":     return K_LPAREN;
            ")":     return K_RPAREN;
            "[":     return K_LBRACKET;
            "]":     return K_RBRACKET;
            default: return K_ILLEGAL;
        endcase
    endfunction

    function automatic pair_t pair_kind(input logic [7:0] a, input logic [7:0] b);
        pair_t p;
        p = '{paired: 1'b0, comment: 1'b0, kind: K_ILLEGAL};
        case (a)
            "=": begin
                if (b == "=") p = '{1'b1, 1'b0, K_EQ};
                else if (b == ">") p = '{1'b1, 1'b0, K_YIELD};
            end
            ":": if (b == "=") p = '{1'b1, 1'b0, K_DECLARE};
            "|": begin
                if (b == ">") p = '{1'b1, 1'b0, K_PIPE};
                else if (b == "|") p = '{1'b1, 1'b0, K_OR};
            end
            "&": if (b == "&") p = '{1'b1, 1'b0, K_AND};
            "!": if (b == "=") p = '{1'b1, 1'b0, K_NOT_EQ};
            "<": begin
                if (b == "=") p = '{1'b1, 1'b0, K_LTE};
                else if (b == "<") p = '{1'b1, 1'b0, K_PUSH};
            end
            ">": if (b == "=") p = '{1'b1, 1'b0, K_GTE};
            "+": if (b == "=") p = '{1'b1, 1'b0, K_PLUS_EQ};
            "-": if (b == "=") p = '{1'b1, 1'b0, K_MINUS_EQ};
            "*": if (b == "=") p = '{1'b1, 1'b0, K_MUL_EQ};
            "/": begin
                if (b == CH_SLASH) p = '{1'b0, 1'b1, K_ILLEGAL};
                else if (b == "=") p = '{1'b1, 1'b0, K_DIV_EQ};
            end
            default: p = '{1'b0, 1'b0, K_ILLEGAL};
        endcase
        return p;
    endfunction

endpackage

// File: hw/rtl/sbt_if.sv
// ----------------------------------------------------------------------------
// sbt_if
// Valid/ready channel carrying a generic payload.
// ----------------------------------------------------------------------------
interface sbt_if #(
    parameter int WIDTH = 8
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/sbt_scan.sv
// ----------------------------------------------------------------------------
// sbt_scan
// Scanner state and per-byte token decision, up to three tokens per byte.
// ----------------------------------------------------------------------------
module sbt_scan #(
    parameter int LB = 12,
    parameter int PB = 16,
    parameter int OB = 24,
    parameter int TW = 6 + 2 * PB + OB + LB
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       text_byte,
    input  logic             end_of_input,
    output logic [2:0]       tok_valid,
    output logic [3*TW-1:0]  tok_data
);
    localparam logic [PB-1:0] PMAX = {PB{1'b1}};
    localparam logic [OB-1:0] OMAX = {OB{1'b1}};
    localparam logic [LB-1:0] LMAX = {LB{1'b1}};

    sbt_pkg::mode_t mode_reg, mode_next;
    logic [7:0]    held_reg, held_next;
    logic [PB-1:0] line_reg, line_next, col_reg, col_next;
    logic [OB-1:0] off_reg, off_next;
    logic [PB-1:0] tline_reg, tline_next, tcol_reg, tcol_next, dcol_reg, dcol_next;
    logic [OB-1:0] toff_reg, toff_next, doff_reg, doff_next;
    logic [LB-1:0] len_reg, len_next;
    logic          fin_reg, fin_next;

    logic [PB-1:0] col;
    logic [OB-1:0] off1;
    logic [LB-1:0] len1;
    logic          endm, flush, idle_go;
    logic [TW-1:0] tk [3];
    logic [1:0]    n;
    logic [7:0]    c;
    sbt_pkg::pair_t pk;

    function automatic logic [TW-1:0] mk(input logic [5:0] k, input logic [PB-1:0] l,
        input logic [PB-1:0] cc, input logic [OB-1:0] o, input logic [LB-1:0] ln);
        return {k, l, cc, o, ln};
    endfunction

    assign c    = text_byte;
    assign endm = end_of_input || c == 8'd0;
    assign col  = (col_reg == PMAX) ? PMAX : col_reg + 1'b1;
    assign off1 = (off_reg == OMAX) ? OMAX : off_reg + 1'b1;
    assign len1 = (len_reg == LMAX) ? LMAX : len_reg + 1'b1;
    assign pk   = sbt_pkg::pair_kind(held_reg, c);

    // next state and emitted tokens
    always_comb
    begin
        logic [5:0] fk;
        mode_next = mode_reg; held_next = held_reg; line_next = line_reg;
        col_next = col_reg; off_next = off_reg; tline_next = tline_reg;
        tcol_next = tcol_reg; toff_next = toff_reg; dcol_next = dcol_reg;
        doff_next = doff_reg; len_next = len_reg; fin_next = fin_reg;
        tk[0] = '0; tk[1] = '0; tk[2] = '0; n = 2'd0;
        flush = 1'b0; idle_go = 1'b0;
        case (mode_reg)
            sbt_pkg::M_OP:      fk = (held_reg == sbt_pkg::CH_AMP) ? sbt_pkg::K_ILLEGAL
                                     : sbt_pkg::single_kind(held_reg);
            sbt_pkg::M_IDENT:   fk = sbt_pkg::K_IDENT;
            sbt_pkg::M_INT:     fk = sbt_pkg::K_INT;
            sbt_pkg::M_INT_DOT: fk = sbt_pkg::K_INT;
            sbt_pkg::M_FRAC:    fk = sbt_pkg::K_FLOAT;
            default:            fk = sbt_pkg::K_ILLEGAL;
        endcase
        if (!fin_reg) begin
            if (endm) begin
                flush = 1'b1;
            end else begin
                case (mode_reg)
                    sbt_pkg::M_OP: begin
                        if (pk.comment) mode_next = sbt_pkg::M_COMMENT;
                        else if (pk.paired) begin
                            tk[0] = mk(pk.kind, tline_reg, tcol_reg, toff_reg, LB'(2));
                            n = 2'd1;
                            len_next = LB'(2);
                            mode_next = sbt_pkg::M_IDLE;
                        end else begin
                            flush = 1'b1; idle_go = 1'b1;
                        end
                    end
                    sbt_pkg::M_IDENT: begin
                        if (sbt_pkg::is_letter(c) || sbt_pkg::is_digit(c)) len_next = len1;
                        else begin flush = 1'b1; idle_go = 1'b1; end
                    end
                    sbt_pkg::M_INT: begin
                        if (sbt_pkg::is_digit(c)) len_next = len1;
                        else if (c == sbt_pkg::CH_DOT) begin
                            dcol_next = col; doff_next = off_reg;
                            mode_next = sbt_pkg::M_INT_DOT;
                        end else begin flush = 1'b1; idle_go = 1'b1; end
                    end
                    sbt_pkg::M_INT_DOT: begin
                        if (sbt_pkg::is_digit(c)) begin
                            len_next = (len1 == LMAX) ? LMAX : len1 + 1'b1;
                            mode_next = sbt_pkg::M_FRAC;
                        end else begin flush = 1'b1; idle_go = 1'b1; end
                    end
                    sbt_pkg::M_FRAC: begin
                        if (sbt_pkg::is_digit(c)) len_next = len1;
                        else begin flush = 1'b1; idle_go = 1'b1; end
                    end
                    sbt_pkg::M_STRING: begin
                        if (c == sbt_pkg::CH_QUOTE) begin
                            tk[0] = mk(sbt_pkg::K_STRING, tline_reg, tcol_reg, toff_reg, len_reg);
                            n = 2'd1;
                            mode_next = sbt_pkg::M_IDLE;
                        end else begin
                            len_next = len1;
                            if (c == sbt_pkg::CH_BACKSLASH) mode_next = sbt_pkg::M_ESC;
                        end
                    end
                    sbt_pkg::M_ESC: begin
                        len_next = len1; mode_next = sbt_pkg::M_STRING;
                    end
                    sbt_pkg::M_COMMENT: if (c == sbt_pkg::CH_LF) mode_next = sbt_pkg::M_IDLE;
                    default: idle_go = 1'b1;
                endcase
            end
            // flush of the pending token
            if (flush && mode_reg != sbt_pkg::M_IDLE && mode_reg != sbt_pkg::M_COMMENT) begin
                tk[0] = mk(fk, tline_reg, tcol_reg, toff_reg, len_reg);
                n = 2'd1;
                if (mode_reg == sbt_pkg::M_INT_DOT) begin
                    tk[1] = mk(sbt_pkg::K_DOT, tline_reg, dcol_reg, doff_reg, LB'(1));
                    n = 2'd2;
                end
            end
            if (flush) mode_next = sbt_pkg::M_IDLE;
            if (endm) begin
                tk[n] = mk(sbt_pkg::K_EOF, line_reg, col, off_reg, '0);
                n = n + 2'd1;
                fin_next = 1'b1;
            end else begin
                // byte handled from idle
                if (idle_go && !sbt_pkg::is_space(c)) begin
                    tline_next = line_reg; tcol_next = col; toff_next = off_reg;
                    len_next = LB'(1);
                    if (sbt_pkg::is_letter(c)) mode_next = sbt_pkg::M_IDENT;
                    else if (sbt_pkg::is_digit(c)) mode_next = sbt_pkg::M_INT;
                    else if (c == sbt_pkg::CH_QUOTE) begin
                        toff_next = off1; len_next = '0; mode_next = sbt_pkg::M_STRING;
                    end else if (sbt_pkg::pairable(c)) begin
                        mode_next = sbt_pkg::M_OP; held_next = c;
                    end else begin
                        tline_next = tline_reg; tcol_next = tcol_reg; toff_next = toff_reg;
                        len_next = (flush && mode_reg != sbt_pkg::M_IDLE) ? len_reg : len_reg;
                        tk[n] = mk(sbt_pkg::single_kind(c), line_reg, col, off_reg, LB'(1));
                        n = n + 2'd1;
                        mode_next = sbt_pkg::M_IDLE;
                    end
                end else if (idle_go) begin
                    mode_next = sbt_pkg::M_IDLE;
                end
                col_next = col; off_next = off1;
                if (c == sbt_pkg::CH_LF) begin
                    line_next = (line_reg == PMAX) ? PMAX : line_reg + 1'b1;
                    col_next = '0;
                end
            end
        end
    end

    assign tok_valid = {n == 2'd3, n >= 2'd2, n != 2'd0};
    assign tok_data  = {tk[2], tk[1], tk[0]};

    // scanner state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= sbt_pkg::M_IDLE; held_reg <= '0; line_reg <= PB'(1);
            col_reg <= '0; off_reg <= '0; tline_reg <= '0; tcol_reg <= '0;
            toff_reg <= '0; len_reg <= '0; fin_reg <= 1'b0; dcol_reg <= '0; doff_reg <= '0;
        end else if (step) begin
            mode_reg <= mode_next; held_reg <= held_next; line_reg <= line_next;
            col_reg <= col_next; off_reg <= off_next; tline_reg <= tline_next;
            tcol_reg <= tcol_next; toff_reg <= toff_next; len_reg <= len_next;
            fin_reg <= fin_next; dcol_reg <= dcol_next; doff_reg <= doff_next;
        end
    end
endmodule

// File: hw/rtl/sbt_outq.sv
// ----------------------------------------------------------------------------
// sbt_outq
// Small token queue that serializes the tokens of one byte onto the output.
// ----------------------------------------------------------------------------
module sbt_outq #(
    parameter int TW = 64
)(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  logic [2:0]      push_valid,
    input  logic [3*TW-1:0] push_data,
    output logic            room,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [TW:0]     out_data
);
    // entries carry the token and its last-of-run flag
    localparam int DEPTH = 8;
    logic [TW:0]  mem_reg [DEPTH];
    logic [2:0]   wp_reg, rp_reg;
    logic [3:0]   cnt_reg, cnt_next;
    logic [1:0]   np;
    logic         pop;

    assign np        = 2'(push_valid[0]) + 2'(push_valid[1]) + 2'(push_valid[2]);
    assign out_valid = cnt_reg != 4'd0;
    assign out_data  = mem_reg[rp_reg];
    assign pop       = out_valid && out_ready;
    assign room      = cnt_reg <= 4'(DEPTH - 3);
    assign cnt_next  = cnt_reg + (push ? 4'(np) : 4'd0) - (pop ? 4'd1 : 4'd0);

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push) begin
            for (int i = 0; i < 3; i++) begin
                if (push_valid[i]) begin
                    mem_reg[3'(wp_reg + 3'(i))] <=
                        {push_data[i*TW +: TW], (2'(i) == np - 2'd1)};
                end
            end
        end
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + 3'(np);
            if (pop) rp_reg <= rp_reg + 3'd1;
            cnt_reg <= cnt_next;
        end
    end
endmodule

// File: hw/rtl/source_byte_tokenizer.sv
// ----------------------------------------------------------------------------
// source_byte_tokenizer
// Streaming tokenizer: source bytes in, tokens out.
// ----------------------------------------------------------------------------
// text_ch carries one byte transfer {end_of_input, text_byte}; a zero byte or
// end_of_input flushes any pending token and then gives END_OF_FILE, after
// which transfers are taken and dropped until reset.
// token_ch carries one token per transfer: {token_kind, start_line,
// start_column, start_offset, token_length, last_of_run}.
// One byte is taken per cycle while the queue has room; the scanner decides in
// the cycle of the transfer and its tokens are registered into an eight-entry
// queue. A byte yields up to three tokens; the queue drains one token a cycle
// while token_ch ready is high, so a burst of multi-token bytes may hold
// text_ch ready low until three entries are free again.
// When the receiver stalls, tokens wait in the queue and text_ch ready falls
// once fewer than three entries are free.
// Reset empties the queue and returns to line 1, column 0, offset 0.
// ----------------------------------------------------------------------------
module source_byte_tokenizer #(
    parameter int LENGTH_BITS   = 12,
    parameter int POSITION_BITS = 16,
    parameter int OFFSET_BITS   = 24
)(
    input logic clk,
    input logic rst_n,
    sbt_if.sink   text_ch,
    sbt_if.source token_ch
);
    localparam int TW = 6 + 2 * POSITION_BITS + OFFSET_BITS + LENGTH_BITS;

    logic [2:0]      tok_valid;
    logic [3*TW-1:0] tok_data;
    logic            room, step;

    assign text_ch.ready = room;
    assign step          = text_ch.valid && room;

    // per-byte scanner
    sbt_scan #(
        .LB(LENGTH_BITS), .PB(POSITION_BITS), .OB(OFFSET_BITS), .TW(TW)
    ) u_scan (
        .clk(clk), .rst_n(rst_n), .step(step),
        .text_byte(text_ch.data[7:0]), .end_of_input(text_ch.data[8]),
        .tok_valid(tok_valid), .tok_data(tok_data)
    );

    // token queue
    sbt_outq #(.TW(TW)) u_outq (
        .clk(clk), .rst_n(rst_n), .push(step), .push_valid(tok_valid),
        .push_data(tok_data), .room(room), .out_valid(token_ch.valid),
        .out_ready(token_ch.ready), .out_data(token_ch.data)
    );
endmodule
